>>> rtl/core/iswb_pkg.sv
// iswb_pkg: shared types, sizes, register indexes and saturating time helpers
// for the IMU sample window buffer. No dependencies.
`timescale 1ns / 1ps

package iswb_pkg;

  // Store geometry and result cap
  localparam int DEPTH    = 1024;
  localparam int MAX_OUT  = 64;
  localparam int AW       = $clog2(DEPTH);          // slot index width
  localparam int CW       = $clog2(DEPTH + 1);      // fill / sweep count width
  localparam int KW       = 64 + AW;                // ordering key width
  localparam int WCW      = $clog2(MAX_OUT + 1);    // result counter width
  localparam int NUM_AXES = 6;
  localparam int DIV_STEPS = 16;                    // Q0.16 alpha bits
  localparam int SW       = $clog2(DIV_STEPS);      // step counter width

  // Configuration register indexes
  localparam logic CFG_KEEP   = 1'b0;
  localparam logic CFG_MARGIN = 1'b1;

  // Commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Reset values
  localparam logic [61:0] KEEP_RST   = 62'd5000000000;
  localparam logic [39:0] MARGIN_RST = 40'd20000000;
  localparam logic [63:0] I64_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] I64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef logic [NUM_AXES-1:0][31:0] ax_vec_t;

  typedef struct packed {
    logic [63:0] t;
    ax_vec_t     ax;
  } item_t;

  // a - m, clamped at the most negative value
  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [61:0] m);
    logic [64:0] d;
    begin
      d = {a[63], a} - {3'b000, m};
      sat_sub = (d[64] != d[63]) ? I64_MIN : d[63:0];
    end
  endfunction

  // a + m, clamped at the most positive value
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [61:0] m);
    logic [64:0] d;
    begin
      d = {a[63], a} + {3'b000, m};
      sat_add = (d[64] != d[63]) ? I64_MAX : d[63:0];
    end
  endfunction

  // Signed time mapped to an unsigned ordering value
  function automatic logic [63:0] tkey(input logic [63:0] t);
    tkey = {~t[63], t[62:0]};
  endfunction

endpackage

>>> rtl/core/imu_sample_window_buffer_unit.sv
// imu_sample_window_buffer_unit: ring store of timestamped IMU samples with
// windowed range pops, run by one compare/sweep unit under a small sequencer.
// Depends on iswb_pkg.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+------------------------------
//  input   | in_command .. in_slack_after_ns    | in_valid / in_stall
//  result  | out_time_ns .. out_found, out_last | out_valid / out_stall
//  config  | cfg_index, cfg_data                | cfg_we, no wait
//
// A push is written in idle and the block is ready again at once.
// A pop makes sorted-order searches over all DEPTH entries, one entry per cycle
// through the single store read port: three to place the range edges, then one
// per interior result and one more; an interpolated result adds a divide and a multiply.
// Validity comes from a fill count, so there is no clearing pass after reset.
// A stalled result stalls the sequencer only when it has a new result to move out.
`timescale 1ns / 1ps

module imu_sample_window_buffer_unit
  import iswb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [61:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_timestamp_ns,
  input  logic [31:0] in_accel_x,
  input  logic [31:0] in_accel_y,
  input  logic [31:0] in_accel_z,
  input  logic [31:0] in_gyro_x,
  input  logic [31:0] in_gyro_y,
  input  logic [31:0] in_gyro_z,
  input  logic [63:0] in_range_end_ns,
  input  logic [61:0] in_slack_before_ns,
  input  logic [61:0] in_slack_after_ns,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_time_ns,
  output logic [31:0] out_accel_x,
  output logic [31:0] out_accel_y,
  output logic [31:0] out_accel_z,
  output logic [31:0] out_gyro_x,
  output logic [31:0] out_gyro_y,
  output logic [31:0] out_gyro_z,
  output logic        out_found,
  output logic        out_last
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_SCAN  = 12'b0000_0000_0010,
    ST_LEAD  = 12'b0000_0000_0100,
    ST_TRAIL = 12'b0000_0000_1000,
    ST_LDA   = 12'b0000_0001_0000,
    ST_CAPA  = 12'b0000_0010_0000,
    ST_LDB   = 12'b0000_0100_0000,
    ST_CAPB  = 12'b0000_1000_0000,
    ST_DIV   = 12'b0001_0000_0000,
    ST_MUL   = 12'b0010_0000_0000,
    ST_DELIV = 12'b0100_0000_0000,
    ST_FIN   = 12'b1000_0000_0000
  } state_t;

  // Which search the sweep is running
  typedef enum logic [3:0] {
    PH_P = 4'b0001,   // latest sample before start
    PH_F = 4'b0010,   // first sample at or after start
    PH_L = 4'b0100,   // latest sample at or before end
    PH_N = 4'b1000    // first sample after the threshold time
  } phase_t;

  // ---------------------------------------------------------------- registers
  state_t         state_r, state_nxt;
  phase_t         phase_r, phase_nxt;
  logic [61:0]    keep_r, keep_nxt;
  logic [39:0]    margin_r, margin_nxt;
  logic [AW-1:0]  ws_r, ws_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [63:0]    newest_r, newest_nxt;
  logic [63:0]    purge_r, purge_nxt;
  logic [63:0]    start_r, start_nxt, end_r, end_nxt;
  logic [63:0]    rstart_r, rstart_nxt, rend_r, rend_nxt;
  logic [63:0]    floor_r, floor_nxt, thr_r, thr_nxt, last_t_r, last_t_nxt;
  logic [CW-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic           rd_live_r;
  logic [AW-1:0]  rd_tag_r;
  item_t          mem_q_r;
  logic           best_v_r, best_v_nxt;
  logic [KW-1:0]  best_key_r, best_key_nxt;
  logic [AW-1:0]  best_slot_r, best_slot_nxt;
  logic           p_v_r, p_v_nxt, f_v_r, f_v_nxt, l_v_r, l_v_nxt;
  logic [63:0]    p_t_r, p_t_nxt, f_t_r, f_t_nxt, l_t_r, l_t_nxt;
  logic [AW-1:0]  p_slot_r, p_slot_nxt, f_slot_r, f_slot_nxt, l_slot_r, l_slot_nxt;
  logic           emit_any_r, emit_any_nxt, fin_after_r, fin_after_nxt;
  logic           interp_r, interp_nxt;
  logic [63:0]    tgt_r, tgt_nxt;
  logic [AW-1:0]  slot_a_r, slot_a_nxt, slot_b_r, slot_b_nxt;
  logic [63:0]    a_t_r, a_t_nxt;
  ax_vec_t        a_ax_r, a_ax_nxt, b_ax_r, b_ax_nxt, res_r, res_nxt;
  logic [63:0]    rem_r, rem_nxt, span_r, span_nxt;
  logic [15:0]    alpha_r, alpha_nxt;
  logic [SW-1:0]  step_r, step_nxt;
  logic signed [49:0] prod_r, prod_nxt;
  logic [31:0]    pa_r, pa_nxt;
  item_t          cand_r, cand_nxt, pend_r, pend_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [WCW-1:0] written_r, written_nxt;
  logic           out_v_r, out_v_nxt;
  item_t          out_item_r, out_item_nxt;
  logic           out_found_r, out_found_nxt, out_last_r, out_last_nxt;

  item_t          mem [DEPTH];

  // ---------------------------------------------------------------- helpers
  logic           in_acc, push_acc, pop_acc, out_free;
  item_t          in_item, item_sel;
  logic [AW-1:0]  rd_addr;
  logic           rd_issue;
  logic [63:0]    q_t, scan_x, best_t, keep_floor, mark;
  logic [AW-1:0]  q_pos;
  logic [KW-1:0]  q_key;
  logic           q_in_win, q_lt, q_gt, q_cond, q_better, is_min;
  logic [64:0]    rem2;
  logic signed [32:0] diff;
  logic signed [49:0] q_scaled;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign push_acc = in_acc && (in_command == CMD_PUSH);
  assign pop_acc  = in_acc && (in_command == CMD_POP);
  assign out_free = !out_v_r || !out_stall;

  assign in_item.t  = in_timestamp_ns;
  assign in_item.ax = {in_gyro_z, in_gyro_y, in_gyro_x, in_accel_z, in_accel_y, in_accel_x};

  assign item_sel.t  = interp_r ? tgt_r : cand_r.t;
  assign item_sel.ax = interp_r ? res_r : cand_r.ax;

  // Store read address
  always_comb begin
    rd_issue = 1'b0;
    rd_addr  = slot_a_r;
    case (state_r)
      ST_SCAN: begin
        rd_addr  = scan_cnt_r[AW-1:0];
        rd_issue = (scan_cnt_r < CW'(DEPTH));
      end
      ST_LDB:  rd_addr = slot_b_r;
      default: rd_addr = slot_a_r;
    endcase
  end

  // Sweep compare unit: qualifies the entry read last cycle and ranks it
  assign q_t = mem_q_r.t;
  always_comb begin
    if (rd_tag_r >= ws_r) q_pos = rd_tag_r - ws_r;
    else                  q_pos = AW'(CW'(rd_tag_r) + CW'(DEPTH) - CW'(ws_r));
  end
  assign q_key    = {tkey(q_t), q_pos};
  assign q_in_win = (CW'(rd_tag_r) < fill_r) && ($signed(q_t) >= $signed(floor_r));
  assign scan_x   = (phase_r == PH_L) ? end_r : ((phase_r == PH_N) ? thr_r : start_r);
  assign q_lt     = $signed(q_t) < $signed(scan_x);
  assign q_gt     = $signed(q_t) > $signed(scan_x);
  assign is_min   = (phase_r == PH_F) || (phase_r == PH_N);
  always_comb begin
    case (phase_r)
      PH_P:    q_cond = q_lt;
      PH_F:    q_cond = !q_lt;
      PH_L:    q_cond = !q_gt;
      PH_N:    q_cond = q_gt;
      default: q_cond = 1'b0;
    endcase
  end
  assign q_better = !best_v_r || (is_min ? (q_key < best_key_r) : (q_key > best_key_r));
  assign best_t   = {~best_key_r[KW-1], best_key_r[KW-2:AW]};

  // Window floor and new purge mark
  assign keep_floor = sat_sub(newest_r, keep_r);
  assign mark       = sat_sub(start_r, {22'd0, margin_r});

  // Shared divide step and multiply
  assign rem2     = {rem_r, 1'b0};
  assign diff     = $signed({b_ax_r[0][31], b_ax_r[0]}) - $signed({a_ax_r[0][31], a_ax_r[0]});
  assign q_scaled = prod_r >>> 16;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    keep_nxt      = keep_r;
    margin_nxt    = margin_r;
    ws_nxt        = ws_r;
    fill_nxt      = fill_r;
    newest_nxt    = newest_r;
    purge_nxt     = purge_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    rstart_nxt    = rstart_r;
    rend_nxt      = rend_r;
    floor_nxt     = floor_r;
    thr_nxt       = thr_r;
    last_t_nxt    = last_t_r;
    scan_cnt_nxt  = scan_cnt_r;
    best_v_nxt    = best_v_r;
    best_key_nxt  = best_key_r;
    best_slot_nxt = best_slot_r;
    p_v_nxt = p_v_r;  p_t_nxt = p_t_r;  p_slot_nxt = p_slot_r;
    f_v_nxt = f_v_r;  f_t_nxt = f_t_r;  f_slot_nxt = f_slot_r;
    l_v_nxt = l_v_r;  l_t_nxt = l_t_r;  l_slot_nxt = l_slot_r;
    emit_any_nxt  = emit_any_r;
    fin_after_nxt = fin_after_r;
    interp_nxt    = interp_r;
    tgt_nxt       = tgt_r;
    slot_a_nxt    = slot_a_r;
    slot_b_nxt    = slot_b_r;
    a_t_nxt       = a_t_r;
    a_ax_nxt      = a_ax_r;
    b_ax_nxt      = b_ax_r;
    res_nxt       = res_r;
    rem_nxt       = rem_r;
    span_nxt      = span_r;
    alpha_nxt     = alpha_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    pa_nxt        = pa_r;
    cand_nxt      = cand_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    written_nxt   = written_r;
    out_v_nxt     = out_v_r && out_stall;
    out_item_nxt  = out_item_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    // configuration writes
    if (cfg_we) begin
      if (cfg_index == CFG_KEEP) keep_nxt = cfg_data;
      else                       margin_nxt = cfg_data[39:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (push_acc) begin
          ws_nxt = (ws_r == AW'(DEPTH - 1)) ? '0 : ws_r + 1'b1;
          if (fill_r < CW'(DEPTH)) fill_nxt = fill_r + 1'b1;
          if ($signed(in_timestamp_ns) > $signed(newest_r)) newest_nxt = in_timestamp_ns;
        end else if (pop_acc) begin
          start_nxt    = in_timestamp_ns;
          end_nxt      = in_range_end_ns;
          rstart_nxt   = sat_sub(in_timestamp_ns, in_slack_before_ns);
          rend_nxt     = sat_add(in_range_end_ns, in_slack_after_ns);
          floor_nxt    = ($signed(purge_r) > $signed(keep_floor)) ? purge_r : keep_floor;
          emit_any_nxt = 1'b0;
          written_nxt  = '0;
          pend_v_nxt   = 1'b0;
          scan_cnt_nxt = '0;
          best_v_nxt   = 1'b0;
          phase_nxt    = PH_P;
          if ($signed(in_range_end_ns) < $signed(in_timestamp_ns)) state_nxt = ST_FIN;
          else                                                     state_nxt = ST_SCAN;
        end
      end

      // one entry per cycle; dispatch after the last one is ranked
      ST_SCAN: begin
        if (rd_issue) scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (rd_live_r && q_in_win && q_cond && q_better) begin
          best_v_nxt    = 1'b1;
          best_key_nxt  = q_key;
          best_slot_nxt = rd_tag_r;
        end
        if (!rd_issue && !rd_live_r) begin
          scan_cnt_nxt = '0;
          case (phase_r)
            PH_P: begin
              p_v_nxt = best_v_r;  p_t_nxt = best_t;  p_slot_nxt = best_slot_r;
              best_v_nxt = 1'b0;
              phase_nxt  = PH_F;
            end
            PH_F: begin
              f_v_nxt = best_v_r;  f_t_nxt = best_t;  f_slot_nxt = best_slot_r;
              best_v_nxt = 1'b0;
              phase_nxt  = PH_L;
            end
            PH_L: begin
              l_v_nxt = best_v_r;  l_t_nxt = best_t;  l_slot_nxt = best_slot_r;
              state_nxt = ST_LEAD;
            end
            default: begin
              // interior: next distinct time inside the range, else trailing edge
              if (best_v_r && ($signed(best_t) <= $signed(end_r))) begin
                slot_a_nxt    = best_slot_r;
                interp_nxt    = 1'b0;
                thr_nxt       = best_t;
                fin_after_nxt = 1'b0;
                state_nxt     = ST_LDA;
              end else begin
                state_nxt = ST_TRAIL;
              end
            end
          endcase
        end
      end

      // leading sample: exact, interpolated, or nearest earlier within slack; else search on
      ST_LEAD: begin
        thr_nxt       = start_r;
        fin_after_nxt = 1'b0;
        tgt_nxt       = start_r;
        if (f_v_r && (f_t_r == start_r)) begin
          slot_a_nxt = f_slot_r;
          interp_nxt = 1'b0;
          state_nxt  = ST_LDA;
        end else if (p_v_r && f_v_r && ($signed(f_t_r) <= $signed(rend_r))) begin
          slot_a_nxt = p_slot_r;
          slot_b_nxt = f_slot_r;
          interp_nxt = 1'b1;
          state_nxt  = ST_LDA;
        end else if (p_v_r && ($signed(p_t_r) >= $signed(rstart_r))) begin
          slot_a_nxt = p_slot_r;
          interp_nxt = 1'b0;
          state_nxt  = ST_LDA;
        end else begin
          best_v_nxt = 1'b0;
          phase_nxt  = PH_N;
          state_nxt  = ST_SCAN;
        end
      end

      // trailing sample; best_* holds the first sample past the end
      ST_TRAIL: begin
        fin_after_nxt = 1'b1;
        tgt_nxt       = end_r;
        if (emit_any_r && (last_t_r == end_r)) begin
          state_nxt = ST_FIN;
        end else if (l_v_r && best_v_r && ($signed(l_t_r) < $signed(end_r)) &&
                     ($signed(best_t) <= $signed(rend_r))) begin
          slot_a_nxt = l_slot_r;
          slot_b_nxt = best_slot_r;
          interp_nxt = 1'b1;
          state_nxt  = ST_LDA;
        end else if (best_v_r && ($signed(best_t) <= $signed(rend_r))) begin
          slot_a_nxt = best_slot_r;
          interp_nxt = 1'b0;
          state_nxt  = ST_LDA;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_LDA: state_nxt = ST_CAPA;

      ST_CAPA: begin
        cand_nxt = mem_q_r;
        a_t_nxt  = mem_q_r.t;
        a_ax_nxt = mem_q_r.ax;
        state_nxt = interp_r ? ST_LDB : ST_DELIV;
      end

      ST_LDB: state_nxt = ST_CAPB;

      ST_CAPB: begin
        b_ax_nxt  = mem_q_r.ax;
        span_nxt  = mem_q_r.t - a_t_r;
        rem_nxt   = tgt_r - a_t_r;
        alpha_nxt = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end

      // restoring divide, one alpha bit per cycle
      ST_DIV: begin
        if (rem_r[63] || (rem2[63:0] >= span_r)) begin
          rem_nxt   = rem2[63:0] - span_r;
          alpha_nxt = {alpha_r[14:0], 1'b1};
        end else begin
          rem_nxt   = rem2[63:0];
          alpha_nxt = {alpha_r[14:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end

      // one axis product per cycle, its scaled add in the cycle after
      ST_MUL: begin
        if (step_r < SW'(NUM_AXES)) begin
          prod_nxt = diff * $signed({1'b0, alpha_r});
          pa_nxt   = a_ax_r[0];
          a_ax_nxt = {32'd0, a_ax_r[NUM_AXES-1:1]};
          b_ax_nxt = {32'd0, b_ax_r[NUM_AXES-1:1]};
        end
        if (step_r != '0) res_nxt = {pa_r + q_scaled[31:0], res_r[NUM_AXES-1:1]};
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(NUM_AXES)) state_nxt = ST_DELIV;
      end

      // hold one result back so the final one can carry last
      ST_DELIV: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_v_nxt     = 1'b1;
            out_item_nxt  = pend_r;
            out_found_nxt = 1'b1;
            out_last_nxt  = 1'b0;
          end
          pend_nxt     = item_sel;
          pend_v_nxt   = 1'b1;
          written_nxt  = written_r + 1'b1;
          last_t_nxt   = item_sel.t;
          emit_any_nxt = 1'b1;
          if (fin_after_r || (written_r + 1'b1 == WCW'(MAX_OUT))) begin
            state_nxt = ST_FIN;
          end else begin
            scan_cnt_nxt = '0;
            best_v_nxt   = 1'b0;
            phase_nxt    = PH_N;
            state_nxt    = ST_SCAN;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_last_nxt = 1'b1;
          if (pend_v_r) begin
            out_item_nxt  = pend_r;
            out_found_nxt = 1'b1;
            if ($signed(mark) > $signed(purge_r)) purge_nxt = mark;
          end else begin
            out_item_nxt  = '0;
            out_found_nxt = 1'b0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_P;
      keep_r      <= KEEP_RST;
      margin_r    <= MARGIN_RST;
      ws_r        <= '0;
      fill_r      <= '0;
      newest_r    <= I64_MIN;
      purge_r     <= I64_MIN;
      rd_live_r   <= 1'b0;
      scan_cnt_r  <= '0;
      best_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      written_r   <= '0;
      emit_any_r  <= 1'b0;
      fin_after_r <= 1'b0;
      interp_r    <= 1'b0;
      step_r      <= '0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      keep_r      <= keep_nxt;
      margin_r    <= margin_nxt;
      ws_r        <= ws_nxt;
      fill_r      <= fill_nxt;
      newest_r    <= newest_nxt;
      purge_r     <= purge_nxt;
      rd_live_r   <= rd_issue;
      scan_cnt_r  <= scan_cnt_nxt;
      best_v_r    <= best_v_nxt;
      pend_v_r    <= pend_v_nxt;
      written_r   <= written_nxt;
      emit_any_r  <= emit_any_nxt;
      fin_after_r <= fin_after_nxt;
      interp_r    <= interp_nxt;
      step_r      <= step_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    rstart_r    <= rstart_nxt;
    rend_r      <= rend_nxt;
    floor_r     <= floor_nxt;
    thr_r       <= thr_nxt;
    last_t_r    <= last_t_nxt;
    best_key_r  <= best_key_nxt;
    best_slot_r <= best_slot_nxt;
    p_v_r <= p_v_nxt;  p_t_r <= p_t_nxt;  p_slot_r <= p_slot_nxt;
    f_v_r <= f_v_nxt;  f_t_r <= f_t_nxt;  f_slot_r <= f_slot_nxt;
    l_v_r <= l_v_nxt;  l_t_r <= l_t_nxt;  l_slot_r <= l_slot_nxt;
    tgt_r       <= tgt_nxt;
    slot_a_r    <= slot_a_nxt;
    slot_b_r    <= slot_b_nxt;
    a_t_r       <= a_t_nxt;
    a_ax_r      <= a_ax_nxt;
    b_ax_r      <= b_ax_nxt;
    res_r       <= res_nxt;
    rem_r       <= rem_nxt;
    span_r      <= span_nxt;
    alpha_r     <= alpha_nxt;
    prod_r      <= prod_nxt;
    pa_r        <= pa_nxt;
    cand_r      <= cand_nxt;
    pend_r      <= pend_nxt;
    out_item_r  <= out_item_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  // ---------------------------------------------------------------- sample store
  always_ff @(posedge clk) begin
    if (push_acc) mem[ws_r] <= in_item;
    mem_q_r  <= mem[rd_addr];
    rd_tag_r <= rd_addr;
  end

  // ---------------------------------------------------------------- outputs
  assign out_valid   = out_v_r;
  assign out_time_ns = out_item_r.t;
  assign out_accel_x = out_item_r.ax[0];
  assign out_accel_y = out_item_r.ax[1];
  assign out_accel_z = out_item_r.ax[2];
  assign out_gyro_x  = out_item_r.ax[3];
  assign out_gyro_y  = out_item_r.ax[4];
  assign out_gyro_z  = out_item_r.ax[5];
  assign out_found   = out_found_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  // a held-back result always corresponds to a counted one
  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (written_r != '0))
    else $error("held result without count");

  // never more results than the cap
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    written_r <= WCW'(MAX_OUT))
    else $error("result count over cap");

  // closing a pop always presents a final result and frees the input
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (state_r == ST_IDLE && out_v_r && out_last_r))
    else $error("pop did not close with last");

  // purge mark only moves forward
  a_purge_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($signed(purge_r) >= $signed($past(purge_r))))
    else $error("purge mark moved back");
`endif

endmodule
